// File: src/mlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_pkg - shared types and constants of the midpoint line rasterizer
// Field widths, the line command passed from the classifier to the stepper.
// ----------------------------------------------------------------------------
package mlr_pkg;

   localparam int FIELD_BITS       = 6;   // width of every coordinate field
   localparam int GLYPH_BITS       = 8;
   localparam int COORD_BITS_DEF   = 6;
   localparam int QUEUE_DEPTH_DEF  = 2;
   // decision variable: covers |2*dx| + |2*dy| plus offsets for 6-bit coordinates
   localparam int DEC_BITS         = FIELD_BITS + 4;
   localparam int REQ_DATA_BITS    = 4 * FIELD_BITS + GLYPH_BITS;
   localparam int RSP_DATA_BITS    = 24;

   typedef logic signed [DEC_BITS-1:0] dec_type;

   // one classified line segment, ready for stepping
   typedef struct packed {
      logic [FIELD_BITS-1:0] start_x;
      logic [FIELD_BITS-1:0] start_y;
      logic [FIELD_BITS-1:0] length;     // pixel count minus one
      logic                  major_y;    // y is the stepping axis
      logic                  y_dec;      // y moves downward
      logic                  minor_en;   // minor axis may step at all
      logic                  step_on_gt; // minor steps when d > 0, else when d < 0
      dec_type               d_init;
      dec_type               d_major;    // added on every step
      dec_type               d_minor;    // added when the minor axis steps
      logic [GLYPH_BITS-1:0] glyph;
   } line_cmd_type;

endpackage
`default_nettype wire

// File: src/mlr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_front - line classifier
// Masks the endpoints, orients the segment and selects one of six cases,
// producing start point, length and midpoint increments.
// ----------------------------------------------------------------------------
module mlr_front #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  wire logic [mlr_pkg::REQ_DATA_BITS-1:0] req_data,
   output mlr_pkg::line_cmd_type                  cmd
);
   localparam int FB = mlr_pkg::FIELD_BITS;
   localparam int DB = mlr_pkg::DEC_BITS;
   localparam logic [FB-1:0] CoordMask = FB'((1 << COORD_BITS) - 1);

   logic [FB-1:0] ax, ay, bx, by;
   logic [FB-1:0] x0, y0, x1, y1;
   logic [DB-1:0] dx, dy, neg_dy;
   logic signed [DB-1:0] sdx, sdy;
   logic          swap;

   always_comb begin
      ax = req_data[FB-1:0] & CoordMask;
      ay = req_data[2*FB-1:FB] & CoordMask;
      bx = req_data[3*FB-1:2*FB] & CoordMask;
      by = req_data[4*FB-1:3*FB] & CoordMask;

      swap = ax > bx;
      x0 = swap ? bx : ax;
      y0 = swap ? by : ay;
      x1 = swap ? ax : bx;
      y1 = swap ? ay : by;

      dx = {{(DB-FB){1'b0}}, x1} - {{(DB-FB){1'b0}}, x0};
      dy = {{(DB-FB){1'b0}}, y1} - {{(DB-FB){1'b0}}, y0};
      neg_dy = -dy;
      sdx = $signed(dx);
      sdy = $signed(dy);

      cmd.glyph      = req_data[mlr_pkg::REQ_DATA_BITS-1:4*FB];
      cmd.start_x    = x0;
      cmd.start_y    = y0;
      cmd.length     = dx[FB-1:0];
      cmd.major_y    = 1'b0;
      cmd.y_dec      = 1'b0;
      cmd.minor_en   = 1'b0;
      cmd.step_on_gt = 1'b0;
      cmd.d_init     = '0;
      cmd.d_major    = '0;
      cmd.d_minor    = '0;

      if (ax == bx) begin
         // vertical, ascending y
         cmd.start_x = ax;
         cmd.start_y = (ay < by) ? ay : by;
         cmd.length  = (ay < by) ? (by - ay) : (ay - by);
         cmd.major_y = 1'b1;
      end else if (ay == by) begin
         // horizontal, x already ascending
         cmd.start_y = ay;
      end else if (sdy >= sdx) begin
         // steep positive: d = 2dx - dy, x steps when d > 0
         cmd.length     = dy[FB-1:0];
         cmd.major_y    = 1'b1;
         cmd.minor_en   = 1'b1;
         cmd.step_on_gt = 1'b1;
         cmd.d_init     = $signed((dx <<< 1) - dy);
         cmd.d_major    = $signed(dx <<< 1);
         cmd.d_minor    = $signed(neg_dy <<< 1);
      end else if (sdy <= -sdx) begin
         // steep negative: y descends, x steps when d < 0
         cmd.length     = neg_dy[FB-1:0];
         cmd.major_y    = 1'b1;
         cmd.y_dec      = 1'b1;
         cmd.minor_en   = 1'b1;
         cmd.d_init     = $signed(neg_dy - (dx <<< 1));
         cmd.d_major    = $signed(-(dx <<< 1));
         cmd.d_minor    = $signed(neg_dy <<< 1);
      end else if (sdy > 0) begin
         // shallow positive: y steps up when d < 0
         cmd.minor_en   = 1'b1;
         cmd.d_init     = $signed((neg_dy <<< 1) + dx);
         cmd.d_major    = $signed(neg_dy <<< 1);
         cmd.d_minor    = $signed(dx <<< 1);
      end else begin
         // shallow negative: y steps down when d > 0
         cmd.y_dec      = 1'b1;
         cmd.minor_en   = 1'b1;
         cmd.step_on_gt = 1'b1;
         cmd.d_init     = $signed((neg_dy <<< 1) - dx);
         cmd.d_major    = $signed(neg_dy <<< 1);
         cmd.d_minor    = $signed(-(dx <<< 1));
      end
   end

endmodule
`default_nettype wire

// File: src/mlr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_queue - command queue
// Small register FIFO between the classifier and the stepper.
// ----------------------------------------------------------------------------
module mlr_queue #(
   parameter int DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire mlr_pkg::line_cmd_type push_cmd,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output mlr_pkg::line_cmd_type      pop_cmd
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mlr_pkg::line_cmd_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: src/mlr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_back - pixel stepper
// Walks one line a pixel per cycle while the response is accepted; the stepping
// registers are also the output register of the response channel.
// ----------------------------------------------------------------------------
module mlr_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   output logic                                   cmd_ready,
   input  wire mlr_pkg::line_cmd_type             cmd,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [mlr_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                                   rsp_tlast
);
   localparam int FB = mlr_pkg::FIELD_BITS;

   logic                  active_ff, active_in;
   logic [FB-1:0]         x_ff, x_in, y_ff, y_in, rem_ff, rem_in;
   mlr_pkg::dec_type      d_ff, d_in;
   mlr_pkg::line_cmd_type cur_ff, cur_in;
   logic                  fire, load, minor_go;
   logic [FB-1:0]         y_step;

   assign fire      = active_ff && rsp_tready;
   assign load      = cmd_valid && (!active_ff || (fire && rem_ff == '0));
   assign cmd_ready = load;

   assign rsp_tvalid = active_ff;
   assign rsp_tlast  = rem_ff == '0;
   assign rsp_tdata  = {(mlr_pkg::RSP_DATA_BITS - 2*FB - mlr_pkg::GLYPH_BITS)'(0),
                        cur_ff.glyph, y_ff, x_ff};

   always_comb begin
      minor_go = cur_ff.minor_en && (cur_ff.step_on_gt ? (d_ff > 0) : (d_ff < 0));
      y_step   = cur_ff.y_dec ? y_ff - 1'b1 : y_ff + 1'b1;

      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      cur_in    = cur_ff;

      if (load) begin
         active_in = 1'b1;
         cur_in    = cmd;
         x_in      = cmd.start_x;
         y_in      = cmd.start_y;
         rem_in    = cmd.length;
         d_in      = cmd.d_init;
      end else if (fire) begin
         if (rem_ff == '0) begin
            active_in = 1'b0;
         end else begin
            rem_in = rem_ff - 1'b1;
            d_in   = d_ff + cur_ff.d_major + (minor_go ? cur_ff.d_minor : '0);
            if (cur_ff.major_y) begin
               y_in = y_step;
               x_in = x_ff + FB'(minor_go);
            end else begin
               x_in = x_ff + 1'b1;
               y_in = minor_go ? y_step : y_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

// File: src/midpoint_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer - line segment to pixel stream
// Classifies each segment, queues it, and steps it with an integer midpoint
// decision variable.
//
//   channel | dir | fields (lowest bit up)
//   req_    | in  | start_x, start_y, end_x, end_y, glyph
//   rsp_    | out | pixel_x, pixel_y, pixel_glyph; tlast = last_pixel
//
// A line of n pixels (n = longest axis span + 1, up to 64) is stepped one
// pixel per cycle while the response is accepted; lines back to back follow
// with no gap, as the next command loads on the cycle the last pixel is taken.
// Classification is combinational into a two-entry queue, so requests are
// taken while the stepper runs until the queue fills.
// Synchronous active-high reset empties the queue and the stepper.
// A stalled response holds the stepper; requests stall only on a full queue.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer #(
   parameter int COORD_BITS  = mlr_pkg::COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], glyph[31:24]
   input  wire logic [mlr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pixel_x[5:0], pixel_y[11:6], pixel_glyph[19:12], zero[23:20]
   output logic [mlr_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                                   rsp_tlast
);
   mlr_pkg::line_cmd_type front_cmd, queue_cmd;
   logic                  queue_valid, queue_ready;

   mlr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_data (req_tdata),
      .cmd      (front_cmd)
   );

   mlr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   mlr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd_ready  (queue_ready),
      .cmd        (queue_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
